@@ hdl/rsrw_pkg.sv @@
`timescale 1ns / 1ps

package rsrw_pkg;

	// Default ring depth in slots.
	localparam int DEPTH_DEFAULT = 4096;

	// Field widths.
	localparam int CMD_W    = 3;
	localparam int SEQ_W    = 16;
	localparam int WORD_W   = 32;
	localparam int LEN_W    = 16;
	localparam int STATUS_W = 3;
	localparam int LIMIT_W  = 13;
	localparam int RATE_W   = 20;

	// Register file addressing: one 32-bit register every four bytes.
	localparam int REG_ADDR_W = 3;
	localparam logic REG_WINDOW_LIMIT = 1'b0;
	localparam logic REG_CLOCK_RATE   = 1'b1;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 13'd4096;
	localparam logic [LEN_W-1:0]   MIN_LEN      = 16'd12;
	localparam logic [SEQ_W-1:0]   SEQ_HALF     = 16'h8000;
	localparam int                 JUMP_SECONDS = 20;

	// Commands carried by a request transaction.
	localparam logic [CMD_W-1:0] CMD_INSERT      = 3'd0;
	localparam logic [CMD_W-1:0] CMD_NEWEST      = 3'd1;
	localparam logic [CMD_W-1:0] CMD_EXACT       = 3'd2;
	localparam logic [CMD_W-1:0] CMD_AT_OR_AFTER = 3'd3;
	localparam logic [CMD_W-1:0] CMD_AFTER       = 3'd4;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_INVALID   = 3'd1,
		ST_EMPTY     = 3'd2,
		ST_TOO_LARGE = 3'd3,
		ST_TOO_SMALL = 3'd4,
		ST_MISSING   = 3'd5,
		ST_ERROR     = 3'd6
	} status_t;

	// One slot of the ring as held in memory.
	typedef struct packed {
		logic              valid;
		logic [WORD_W-1:0] handle;
		logic [LEN_W-1:0]  length;
	} slot_t;

endpackage

@@ hdl/rsrw_if.sv @@
`timescale 1ns / 1ps

// Request channel: one command per transaction.
interface rsrw_req_if import rsrw_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CMD_W-1:0]  command;
	logic [SEQ_W-1:0]  seq_number;
	logic [WORD_W-1:0] source_id;
	logic [WORD_W-1:0] media_time;
	logic [LEN_W-1:0]  packet_length;
	logic [WORD_W-1:0] packet_handle;

	modport source (output valid, command, seq_number, source_id, media_time,
		packet_length, packet_handle, input ready);
	modport sink (input valid, command, seq_number, source_id, media_time,
		packet_length, packet_handle, output ready);
endinterface

// Response channel: one result per request.
interface rsrw_rsp_if import rsrw_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [STATUS_W-1:0] status;
	logic [WORD_W-1:0]   found_handle;
	logic [LEN_W-1:0]    found_length;
	logic [SEQ_W-1:0]    found_seq;

	modport source (output valid, status, found_handle, found_length, found_seq,
		input ready);
	modport sink (input valid, status, found_handle, found_length, found_seq,
		output ready);
endinterface

@@ hdl/rsrw_ram.sv @@
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port with registered data.
module rsrw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ hdl/rtp_sequence_reorder_window_core.sv @@
`timescale 1ns / 1ps

// Channel  Role          Handshake        Contents
// req      sink          valid / ready    command, seq_number, source_id, media_time,
//                                         packet_length, packet_handle
// rsp      source        valid / ready    status, found_handle, found_length, found_seq
// APB      slave         psel / penable   window_limit at 0x0, clock_rate at 0x4
//
// One transaction is handled at a time; the slot memory has a single read and write port.
// A lookup reads its slot first and, for at-or-after and after, steps past empty slots; an insert ahead
// of the newest packet writes the gap slots empty, then the packet, and drops empty slots from the front.
// A finished result waits in the output register, and a new request is taken meanwhile.
// No clearing pass is needed after reset: every slot inside the window is written before
// it is read.

module rtp_sequence_reorder_window_core import rsrw_pkg::*; #(
	parameter int WINDOW_DEPTH = DEPTH_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	rsrw_req_if.sink              req,
	rsrw_rsp_if.source            rsp,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [REG_ADDR_W-1:0] paddr,
	input  logic [31:0]           pwdata,
	output logic [31:0]           prdata,
	output logic                  pready
);

	localparam int PW = $clog2(WINDOW_DEPTH);
	localparam int CW = $clog2(WINDOW_DEPTH + 1);
	localparam int SW = CW + 1;
	localparam logic [SW-1:0] DEPTH_S = SW'(WINDOW_DEPTH);
	localparam logic [PW-1:0] LAST_P  = PW'(WINDOW_DEPTH - 1);

	typedef enum logic [8:0] {
		S_IDLE     = 9'b000000001,
		S_EXEC     = 9'b000000010,
		S_GAP      = 9'b000000100,
		S_FILL_CHK = 9'b000001000,
		S_TRIM     = 9'b000010000,
		S_TRIM_CHK = 9'b000100000,
		S_LOOK_CHK = 9'b001000000,
		S_RESP     = 9'b010000000,
		S_SPARE    = 9'b100000000
	} state_t;

	// Ring position of base plus step, where both stay below the depth.
	function automatic logic [PW-1:0] wrap_add(logic [PW-1:0] base, logic [SW-1:0] step);
		logic [SW-1:0] sum;
		sum = SW'(base) + step;
		if (sum >= DEPTH_S) begin
			sum = sum - DEPTH_S;
		end
		return sum[PW-1:0];
	endfunction

	state_t            state_q;
	logic [CMD_W-1:0]  cmd_q;
	logic [SEQ_W-1:0]  seq_q;
	logic [WORD_W-1:0] src_q;
	logic [WORD_W-1:0] time_in_q;
	logic [LEN_W-1:0]  len_q;
	logic [WORD_W-1:0] handle_q;

	logic [PW-1:0]      head_q;
	logic [CW-1:0]      count_q;
	logic [SEQ_W-1:0]   oldest_q;
	logic [SEQ_W-1:0]   newest_q;
	logic [WORD_W-1:0]  locked_q;
	logic [WORD_W-1:0]  newest_time_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [RATE_W-1:0]  rate_q;

	logic [PW-1:0]    wp_q;
	logic [PW-1:0]    rp_q;
	logic [SEQ_W-1:0] gap_q;
	logic [CW-1:0]    rem_q;
	logic [SEQ_W-1:0] cur_seq_q;
	logic             scan_q;
	status_t          miss_q;
	logic             trim_cfg_q;

	status_t           res_status_q;
	logic [WORD_W-1:0] res_handle_q;
	logic [LEN_W-1:0]  res_len_q;
	logic [SEQ_W-1:0]  res_seq_q;

	logic              rsp_valid_q;
	status_t           rsp_status_q;
	logic [WORD_W-1:0] rsp_handle_q;
	logic [LEN_W-1:0]  rsp_len_q;
	logic [SEQ_W-1:0]  rsp_seq_q;
	logic              rsp_load;

	logic          ram_we;
	logic [PW-1:0] ram_waddr;
	slot_t         ram_wdata;
	logic [PW-1:0] ram_raddr;
	slot_t         ram_rdata;

	// Register writes from the configuration port.
	logic cfg_we;
	logic lim_we;
	logic rate_we;

	assign cfg_we  = psel && penable && pwrite;
	assign lim_we  = cfg_we && (paddr[2] == REG_WINDOW_LIMIT);
	assign rate_we = cfg_we && (paddr[2] == REG_CLOCK_RATE);
	assign pready  = 1'b1;
	assign prdata  = (paddr[2] == REG_CLOCK_RATE) ? 32'(rate_q) : 32'(limit_q);

	// Effective window limit, saturated to one up to the ring depth.
	logic [31:0]   lim_wide;
	logic [CW-1:0] lim;

	always_comb begin
		lim_wide = 32'(limit_q);
		if (lim_wide == 32'd0) begin
			lim_wide = 32'd1;
		end else if (lim_wide > 32'(WINDOW_DEPTH)) begin
			lim_wide = 32'(WINDOW_DEPTH);
		end
	end
	assign lim = lim_wide[CW-1:0];

	// Wrap-aware sequence arithmetic for the request held in the item registers.
	logic [SEQ_W-1:0]  d;
	logic [SEQ_W-1:0]  look_b;
	logic [SEQ_W-1:0]  off;
	logic [SEQ_W-1:0]  expect_seq;
	logic [16:0]       ext_sum;
	logic [16:0]       new_count;
	logic [16:0]       pops;
	logic              is_extend;
	logic              is_far;
	logic              in_span;
	logic              off_in;
	logic [WORD_W-1:0] tdiff;
	logic [WORD_W-1:0] tmag;
	logic [24:0]       thresh;
	logic              jump;
	logic [WORD_W-1:0] src_eff;
	logic              ins_ok;
	logic              ins_restart;

	assign d          = seq_q - newest_q;
	assign look_b     = oldest_q - seq_q;
	assign off        = seq_q - oldest_q;
	assign expect_seq = newest_q + 16'(lim);
	assign ext_sum    = 17'(count_q) + 17'(d);
	assign new_count  = (ext_sum > 17'(lim)) ? 17'(lim) : ext_sum;
	assign pops       = ext_sum - new_count;
	assign is_extend  = (d != '0) && (17'(d) < 17'(lim));
	assign is_far     = (seq_q - expect_seq) < (oldest_q - expect_seq);
	assign off_in     = 17'(off) < 17'(count_q);
	assign in_span    = (off <= (newest_q - oldest_q)) && off_in;

	// Timestamp jump: magnitude of the signed difference against twenty seconds of ticks.
	assign tdiff  = newest_time_q - time_in_q;
	assign tmag   = tdiff[WORD_W-1] ? (32'd0 - tdiff) : tdiff;
	assign thresh = 25'(rate_q) * 25'(JUMP_SECONDS);
	assign jump   = (rate_q != '0) && (tmag >= 32'(thresh));

	assign src_eff     = (locked_q == '0) ? src_q : locked_q;
	assign ins_ok      = (len_q >= MIN_LEN) && (src_q == src_eff);
	assign ins_restart = (count_q == '0) || jump || (!is_extend && is_far);

	// Ring positions used by the sequencer.
	logic [PW-1:0] phys_off;
	logic [PW-1:0] phys_last;
	logic [PW-1:0] phys_tail;
	logic [PW-1:0] head_ext;
	logic [PW-1:0] head_trim;
	logic [PW-1:0] head_inc;
	logic [PW-1:0] wp_inc;
	logic [PW-1:0] rp_inc;
	logic [CW-1:0] over;

	assign over      = count_q - lim;
	assign phys_off  = wrap_add(head_q, SW'(off));
	assign phys_last = wrap_add(head_q, SW'(CW'(count_q - 1'b1)));
	assign phys_tail = wrap_add(head_q, SW'(count_q));
	assign head_ext  = wrap_add(head_q, SW'(pops));
	assign head_trim = wrap_add(head_q, SW'(over));
	assign head_inc  = (head_q == LAST_P) ? '0 : head_q + 1'b1;
	assign wp_inc    = (wp_q == LAST_P) ? '0 : wp_q + 1'b1;
	assign rp_inc    = (rp_q == LAST_P) ? '0 : rp_q + 1'b1;

	// Slot memory port control.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wp_q;
		ram_wdata = '0;
		ram_raddr = head_q;
		unique case (state_q)
			S_EXEC: begin
				if (cmd_q == CMD_NEWEST) begin
					ram_raddr = phys_last;
				end else begin
					ram_raddr = phys_off;
				end
				if ((cmd_q == CMD_INSERT) && ins_ok && ins_restart) begin
					ram_we    = 1'b1;
					ram_waddr = '0;
					ram_wdata = '{valid: 1'b1, handle: handle_q, length: len_q};
				end
			end
			S_GAP: begin
				ram_we = 1'b1;
				if (gap_q == '0) begin
					ram_wdata = '{valid: 1'b1, handle: handle_q, length: len_q};
				end
			end
			S_FILL_CHK: begin
				ram_we    = !ram_rdata.valid;
				ram_wdata = '{valid: 1'b1, handle: handle_q, length: len_q};
			end
			S_LOOK_CHK: begin
				ram_raddr = rp_inc;
			end
			default: begin
			end
		endcase
	end

	rsrw_ram #(
		.WIDTH ($bits(slot_t)),
		.DEPTH (WINDOW_DEPTH)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign req.ready         = (state_q == S_IDLE) && !lim_we;
	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = rsp_status_q;
	assign rsp.found_handle  = rsp_handle_q;
	assign rsp.found_length  = rsp_len_q;
	assign rsp.found_seq     = rsp_seq_q;

	// A finished result moves to the output register once that register is free.
	assign rsp_load = (state_q == S_RESP) && (!rsp_valid_q || rsp.ready);

	// Sequencer and window state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			head_q        <= '0;
			count_q       <= '0;
			oldest_q      <= '0;
			newest_q      <= '0;
			locked_q      <= '0;
			newest_time_q <= '0;
			limit_q       <= LIMIT_RESET;
			rate_q        <= '0;
			trim_cfg_q    <= 1'b0;
			rsp_valid_q   <= 1'b0;
		end else begin
			if (rate_we) begin
				rate_q <= pwdata[RATE_W-1:0];
			end

			// The output register fills with a result and empties when its transaction completes.
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (req.valid && req.ready) begin
						cmd_q        <= req.command;
						seq_q        <= (req.command == CMD_AFTER) ?
							req.seq_number + 1'b1 : req.seq_number;
						src_q        <= req.source_id;
						time_in_q    <= req.media_time;
						len_q        <= req.packet_length;
						handle_q     <= req.packet_handle;
						res_handle_q <= '0;
						res_len_q    <= '0;
						res_seq_q    <= '0;
						state_q      <= S_EXEC;
					end
				end

				S_EXEC: begin
					state_q <= S_RESP;
					case (cmd_q)
						CMD_INSERT: begin
							if (len_q < MIN_LEN) begin
								res_status_q <= ST_INVALID;
							end else begin
								locked_q <= src_eff;
								if (src_q != src_eff) begin
									res_status_q <= ST_INVALID;
								end else if (ins_restart) begin
									count_q       <= CW'(1);
									head_q        <= '0;
									oldest_q      <= seq_q;
									newest_q      <= seq_q;
									newest_time_q <= time_in_q;
									res_status_q  <= ST_OK;
								end else if (is_extend) begin
									wp_q          <= phys_tail;
									gap_q         <= d - 1'b1;
									head_q        <= head_ext;
									oldest_q      <= oldest_q + pops[SEQ_W-1:0];
									newest_q      <= seq_q;
									count_q       <= new_count[CW-1:0];
									newest_time_q <= time_in_q;
									trim_cfg_q    <= 1'b0;
									state_q       <= S_GAP;
								end else if (in_span) begin
									wp_q    <= phys_off;
									state_q <= S_FILL_CHK;
								end else begin
									res_status_q <= ST_ERROR;
								end
							end
						end
						CMD_NEWEST: begin
							if (count_q == '0) begin
								res_status_q <= ST_EMPTY;
							end else begin
								rp_q      <= phys_last;
								rem_q     <= '0;
								cur_seq_q <= newest_q;
								scan_q    <= 1'b0;
								miss_q    <= ST_ERROR;
								state_q   <= S_LOOK_CHK;
							end
						end
						CMD_EXACT, CMD_AT_OR_AFTER, CMD_AFTER: begin
							if (count_q == '0) begin
								res_status_q <= ST_EMPTY;
							end else if ((d != '0) && (d < SEQ_HALF)) begin
								res_status_q <= ST_TOO_LARGE;
							end else if ((look_b != '0) && (look_b < SEQ_HALF)) begin
								res_status_q <= ST_TOO_SMALL;
							end else if (!off_in) begin
								res_status_q <= ST_ERROR;
							end else begin
								rp_q      <= phys_off;
								rem_q     <= count_q - CW'(off) - 1'b1;
								cur_seq_q <= seq_q;
								scan_q    <= (cmd_q != CMD_EXACT);
								miss_q    <= (cmd_q == CMD_EXACT) ? ST_MISSING : ST_ERROR;
								state_q   <= S_LOOK_CHK;
							end
						end
						default: begin
							res_status_q <= ST_ERROR;
						end
					endcase
				end

				// Gap slots are written empty, then the new packet at the tail.
				S_GAP: begin
					if (gap_q == '0) begin
						state_q <= S_TRIM;
					end else begin
						wp_q  <= wp_inc;
						gap_q <= gap_q - 1'b1;
					end
				end

				// An empty slot inside the window takes the packet; a duplicate is ignored.
				S_FILL_CHK: begin
					res_status_q <= ST_OK;
					state_q      <= S_RESP;
				end

				// Cut the window to the limit, then look at the front slot.
				S_TRIM: begin
					if (count_q > lim) begin
						head_q   <= head_trim;
						oldest_q <= oldest_q + 16'(over);
						count_q  <= lim;
					end else if (count_q == '0) begin
						res_status_q <= ST_OK;
						state_q      <= trim_cfg_q ? S_IDLE : S_RESP;
					end else begin
						state_q <= S_TRIM_CHK;
					end
				end

				// Drop an empty front slot and go round again.
				S_TRIM_CHK: begin
					if (!ram_rdata.valid) begin
						head_q   <= head_inc;
						oldest_q <= oldest_q + 1'b1;
						count_q  <= count_q - 1'b1;
						state_q  <= S_TRIM;
					end else begin
						res_status_q <= ST_OK;
						state_q      <= trim_cfg_q ? S_IDLE : S_RESP;
					end
				end

				// One slot per cycle: the next read is issued while this one is checked.
				S_LOOK_CHK: begin
					if (ram_rdata.valid) begin
						res_status_q <= ST_OK;
						res_handle_q <= ram_rdata.handle;
						res_len_q    <= ram_rdata.length;
						res_seq_q    <= cur_seq_q;
						state_q      <= S_RESP;
					end else if (scan_q && (rem_q != '0)) begin
						rp_q      <= rp_inc;
						rem_q     <= rem_q - 1'b1;
						cur_seq_q <= cur_seq_q + 1'b1;
					end else begin
						res_status_q <= miss_q;
						state_q      <= S_RESP;
					end
				end

				S_RESP: begin
					if (rsp_load) begin
						rsp_status_q <= res_status_q;
						rsp_handle_q <= res_handle_q;
						rsp_len_q    <= res_len_q;
						rsp_seq_q    <= res_seq_q;
						state_q      <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase

			// A limit write clears the window on zero, otherwise trims it.
			if (lim_we) begin
				limit_q <= pwdata[LIMIT_W-1:0];
				if (pwdata[LIMIT_W-1:0] == '0) begin
					count_q <= '0;
					head_q  <= '0;
					state_q <= S_IDLE;
				end else begin
					trim_cfg_q <= 1'b1;
					state_q    <= S_TRIM;
				end
			end
		end
	end

`ifndef NO_ASSERTIONS
	// At rest the window never spans more slots than the limit allows.
	a_count_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (count_q <= lim))
		else $error("window span exceeds the limit while idle");

	// When idle with a non-empty window, the newest sequence number sits count minus one after the oldest.
	a_span: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_IDLE) && (count_q != '0)) |->
		((newest_q - oldest_q) == 16'(CW'(count_q - 1'b1))))
		else $error("oldest and newest sequence numbers disagree with the count");

	// The ring head stays inside the memory for any depth.
	a_head: assert property (@(posedge clk) disable iff (!arst_n)
		32'(head_q) < WINDOW_DEPTH)
		else $error("ring head beyond the memory depth");
`endif

endmodule
